/* rtl/ncme_pkg.sv */
package ncme_pkg;

  // Automaton size
  localparam int STATE_COUNT  = 64;
  localparam int ACTION_COUNT = 64;

  // Fixed field widths
  localparam int SET_W   = 64;
  localparam int FIELD_W = 6;

  localparam int STATE_W  = $clog2(STATE_COUNT);
  localparam int ACTION_W = $clog2(ACTION_COUNT);
  localparam int ADDR_W   = ACTION_W + STATE_W;

  localparam logic [SET_W-1:0] STATE_MASK = {SET_W{1'b1}} >> (SET_W - STATE_COUNT);

  // Command codes
  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_CLOSE = 2'd1;
  localparam logic [1:0] CMD_MOVE  = 2'd2;

  // Status codes
  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_NONE   = 2'd1;
  localparam logic [1:0] STATUS_EPS    = 2'd2;

  // Walk unit to sequencer
  typedef struct packed {
    logic               rd_en;
    logic [STATE_W-1:0] rd_state;
    logic               done;
  } walk_stat_t;

  // One-hot (lowest member) to state index
  function automatic logic [STATE_W-1:0] onehot_index(input logic [SET_W-1:0] low);
    logic [STATE_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < STATE_COUNT; i++) begin
      if (low[i]) begin
        idx = idx | STATE_W'(i);
      end
    end
    return idx;
  endfunction

  function automatic logic [ADDR_W-1:0] mask_addr(input logic [ACTION_W-1:0] act,
                                                   input logic [STATE_W-1:0] st);
    return {act, st};
  endfunction

endpackage

/* rtl/ncme_ram.sv */
module ncme_ram #(
  parameter int WIDTH  = 64,
  parameter int ADDR_W = 12
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [(1 << ADDR_W)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

/* rtl/ncme_walk.sv */
module ncme_walk (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      close_mode,
  input  logic                      expand,
  input  logic [ncme_pkg::SET_W-1:0] seed,
  input  logic [ncme_pkg::SET_W-1:0] rdata,
  output ncme_pkg::walk_stat_t      stat,
  output logic [ncme_pkg::SET_W-1:0] result
);
  import ncme_pkg::*;

  logic             active;
  logic             inflight;
  logic             close_q;
  logic             rd_en;
  logic             done;
  logic [SET_W-1:0] pending;
  logic [SET_W-1:0] acc;
  logic [SET_W-1:0] low;
  logic [SET_W-1:0] fresh;

  // lowest pending member, isolated
  assign low   = pending & (~pending + {{(SET_W-1){1'b0}}, 1'b1});
  // closure keeps only newly reached states; gather takes the whole mask
  assign fresh = inflight ? (close_q ? (rdata & ~acc) : rdata) : '0;

  assign rd_en  = active && (pending != '0);
  assign done   = active && (pending == '0) && !inflight;
  assign stat   = '{rd_en: rd_en, rd_state: onehot_index(low), done: done};
  assign result = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      inflight <= 1'b0;
    end else if (start) begin
      active   <= 1'b1;
      inflight <= 1'b0;
    end else begin
      if (done) begin
        active <= 1'b0;
      end
      inflight <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      pending <= expand ? seed : '0;
      acc     <= close_mode ? seed : '0;
      close_q <= close_mode;
    end else if (active) begin
      pending <= (pending & ~low) | (close_q ? fresh : '0);
      acc     <= acc | fresh;
    end
  end

endmodule

/* rtl/nfa_closure_move_engine.sv */
// NFA epsilon-closure / move engine.
// Input channel (in_valid / in_stall) takes one request: add transition,
// closure of state_set, or move of state_set on action_number then close.
// Output channel (out_valid / out_stall) returns result_set and status for
// closure and move requests; add requests and unused commands return nothing.
// The user writes epsilon_action through cfg_wr_en / cfg_wr_data only while
// idle; the block itself does not enforce this. Transition masks live in one
// single-port RAM, one 64-bit word per (action, source state). A walk unit
// reads one word per member state, a new read each cycle while members are
// pending, so a request takes about (set members + closure states) reads.
// An add reads the current mask, then writes back the merged mask.
// Reset clears the RAM by a pass over all 2**ADDR_W (4096) words, one word
// per cycle; in_stall stays high meanwhile, configuration writes still land.
// A finished result sits in the output register; a new request is taken
// while it waits, and the engine holds a second result until out_stall drops.
module nfa_closure_move_engine (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          command,
  input  logic [ncme_pkg::FIELD_W-1:0]        source_state,
  input  logic [ncme_pkg::FIELD_W-1:0]        target_state,
  input  logic [ncme_pkg::FIELD_W-1:0]        action_number,
  input  logic [ncme_pkg::SET_W-1:0]          state_set,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ncme_pkg::SET_W-1:0]          result_set,
  output logic [1:0]                          status,
  input  logic                                cfg_wr_en,
  input  logic [ncme_pkg::FIELD_W-1:0]        cfg_wr_data
);
  import ncme_pkg::*;

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_ADD    = 6'b000100,
    ST_MOVE   = 6'b001000,
    ST_CLOSE  = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [ADDR_W-1:0]   clr_addr;
  logic [FIELD_W-1:0]  epsilon_action;
  logic [ADDR_W-1:0]   add_addr;
  logic [SET_W-1:0]    add_bit;
  logic [ACTION_W-1:0] move_act;
  logic [SET_W-1:0]    res_set, res_set_next;
  logic [1:0]          res_status, res_status_next;

  // RAM port
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_addr;
  logic [SET_W-1:0]  ram_wdata, ram_rdata;

  // walk unit
  logic             walk_start, walk_close, walk_expand;
  logic [SET_W-1:0] walk_seed, walk_result;
  walk_stat_t       walk_st;

  logic accept;
  logic eps_ok;
  logic add_ok;
  logic out_free;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  assign eps_ok = int'(epsilon_action) < ACTION_COUNT;
  assign add_ok = (int'(source_state) < STATE_COUNT) && (int'(target_state) < STATE_COUNT)
                  && (int'(action_number) < ACTION_COUNT);

  ncme_ram #(
    .WIDTH  (SET_W),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  ncme_walk u_walk (
    .clk        (clk),
    .rst        (rst),
    .start      (walk_start),
    .close_mode (walk_close),
    .expand     (walk_expand),
    .seed       (walk_seed),
    .rdata      (ram_rdata),
    .stat       (walk_st),
    .result     (walk_result)
  );

  // Sequencer
  always_comb begin
    state_next      = state;
    res_set_next    = res_set;
    res_status_next = res_status;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    ram_addr        = '0;
    ram_wdata       = '0;
    walk_start      = 1'b0;
    walk_close      = 1'b0;
    walk_expand     = 1'b0;
    walk_seed       = '0;

    case (state)
      ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_addr;
        if (&clr_addr) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (command)
            CMD_ADD: begin
              // read the current mask; merge and write back next cycle
              ram_re   = add_ok;
              ram_addr = mask_addr(ACTION_W'(action_number), STATE_W'(source_state));
              if (add_ok) begin
                state_next = ST_ADD;
              end
            end
            CMD_CLOSE: begin
              walk_start  = 1'b1;
              walk_close  = 1'b1;
              walk_expand = eps_ok;
              walk_seed   = state_set & STATE_MASK;
              state_next  = ST_CLOSE;
            end
            CMD_MOVE: begin
              res_set_next = '0;
              if (action_number == epsilon_action) begin
                res_status_next = STATUS_EPS;
                state_next      = ST_FINISH;
              end else if (int'(action_number) >= ACTION_COUNT) begin
                res_status_next = STATUS_NONE;
                state_next      = ST_FINISH;
              end else begin
                walk_start  = 1'b1;
                walk_expand = 1'b1;
                walk_seed   = state_set & STATE_MASK;
                state_next  = ST_MOVE;
              end
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_ADD: begin
        ram_we     = 1'b1;
        ram_addr   = add_addr;
        ram_wdata  = ram_rdata | add_bit;
        state_next = ST_IDLE;
      end
      ST_MOVE: begin
        ram_re   = walk_st.rd_en;
        ram_addr = mask_addr(move_act, walk_st.rd_state);
        if (walk_st.done) begin
          if ((walk_result & STATE_MASK) == '0) begin
            res_set_next    = '0;
            res_status_next = STATUS_NONE;
            state_next      = ST_FINISH;
          end else begin
            // union found: close it
            walk_start  = 1'b1;
            walk_close  = 1'b1;
            walk_expand = eps_ok;
            walk_seed   = walk_result & STATE_MASK;
            state_next  = ST_CLOSE;
          end
        end
      end
      ST_CLOSE: begin
        ram_re   = walk_st.rd_en;
        ram_addr = mask_addr(ACTION_W'(epsilon_action), walk_st.rd_state);
        if (walk_st.done) begin
          res_set_next    = walk_result;
          res_status_next = STATUS_OK;
          state_next      = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_addr       <= '0;
      epsilon_action <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cfg_wr_en) begin
        epsilon_action <= cfg_wr_data;
      end
      if (state == ST_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    res_set    <= res_set_next;
    res_status <= res_status_next;
    if (accept) begin
      add_addr <= mask_addr(ACTION_W'(action_number), STATE_W'(source_state));
      add_bit  <= {{(SET_W-1){1'b0}}, 1'b1} << target_state;
      move_act <= ACTION_W'(action_number);
    end
    if (state == ST_FINISH && out_free) begin
      result_set <= res_set;
      status     <= res_status;
    end
  end

`ifndef SYNTHESIS
  a_rd_only_walking: assert property (@(posedge clk) disable iff (rst)
    walk_st.rd_en |-> (state == ST_MOVE || state == ST_CLOSE))
    else $error("walk read outside move/close");

  a_err_zero_set: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != STATUS_OK) |-> (result_set == '0))
    else $error("nonzero result_set with error status");

  a_close_done_finish: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLOSE && walk_st.done) |=> (state == ST_FINISH))
    else $error("closure done without finish");

  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FINISH))
    else $error("output raised outside finish");
`endif

endmodule
